// ===== rtl/smpq_pkg.sv =====
package smpq_pkg;

	// Number of entries the queue holds.
	localparam int unsigned CAPACITY = 16;

	// Width of the internal fill count, wide enough to hold CAPACITY itself.
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	localparam int unsigned VAL_W = 32;
	localparam int unsigned ENTRY_COUNT_W = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Operation broadcast to every cell in the chain.
	typedef struct packed {
		logic insert;
		logic shift_left;
	} cell_ctrl_t;

endpackage

// ===== rtl/smpq_cell.sv =====
module smpq_cell
	import smpq_pkg::*;
(
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic signed [VAL_W-1:0]  value,
	input  logic                     occupied,
	input  logic signed [VAL_W-1:0]  left_entry,
	input  logic                     left_gt,
	input  logic signed [VAL_W-1:0]  right_entry,
	output logic signed [VAL_W-1:0]  entry,
	output logic                     gt
);

	logic signed [VAL_W-1:0] entry_q;
	logic signed [VAL_W-1:0] entry_d;

	// An empty cell counts as greater, so a new value lands after all held ones.
	assign gt = !occupied || (entry_q > value);

	// Insert: the first greater cell takes the value and every cell after it
	// takes its left neighbor. Delete: every cell takes its right neighbor.
	always_comb begin
		entry_d = entry_q;
		if (ctrl.insert) begin
			if (left_gt) begin
				entry_d = left_entry;
			end else if (gt) begin
				entry_d = value;
			end
		end else if (ctrl.shift_left) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

// ===== rtl/sorted_min_priority_queue_unit.sv =====
// Sorted min-priority queue built as a chain of cells, one entry per cell.
//
// Command channel: cmd_valid / cmd_stall carry command (0 insert, 1 delete
// minimum) and value. Result channel: res_valid / res_stall carry
// removed_value, status and entry_count. Every command gives one result.
//
// All cells compare their entry with the incoming value in parallel and
// shift their neighbor's entry in the same cycle. An item's result sits in
// the output register from the next cycle on. The queue takes one item per
// cycle while the receiver keeps up.
//
// When the receiver stalls, the waiting result holds and cmd_stall rises
// until it is taken, so no more than one result is ever pending.
//
// Reset (arst_n low) empties the queue and drops any pending result. The
// cell contents are not cleared; cells beyond the fill count are never read.
// An insert into a full queue is dropped with status full; a delete from an
// empty queue returns 0 with status empty.
module sorted_min_priority_queue_unit
	import smpq_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  logic                           command,
	input  logic signed [VAL_W-1:0]        value,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic signed [VAL_W-1:0]        removed_value,
	output logic [1:0]                     status,
	output logic [ENTRY_COUNT_W-1:0]       entry_count
);

	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    ins_ok;
	logic                    del_ok;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	logic                    res_valid_q;
	logic signed [VAL_W-1:0] removed_q;
	status_t                 status_q;
	status_t                 status_d;
	logic [CNT_W-1:0]        res_count_q;
	cell_ctrl_t              ctrl;

	logic signed [VAL_W-1:0] entries [CAPACITY];
	logic                    gts     [CAPACITY];

	// Handshake and operation decode.
	assign cmd_stall = res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign ins_ok    = accept && (command == CMD_INSERT) && !full;
	assign del_ok    = accept && (command == CMD_DELETE) && !empty;

	assign ctrl.insert     = ins_ok;
	assign ctrl.shift_left = del_ok;

	// Chain of cells; cell 0 holds the minimum.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_e;
		logic                    left_g;
		logic signed [VAL_W-1:0] right_e;
		logic                    occ;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_e = value;
			assign left_g = 1'b0;
		end else begin : g_mid
			assign left_e = entries[i-1];
			assign left_g = gts[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = entries[i];
		end else begin : g_inner
			assign right_e = entries[i+1];
		end

		smpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.value       (value),
			.occupied    (occ),
			.left_entry  (left_e),
			.left_gt     (left_g),
			.right_entry (right_e),
			.entry       (entries[i]),
			.gt          (gts[i])
		);
	end

	// Fill count update.
	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (del_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// Status of the accepted item.
	always_comb begin
		status_d = ST_OK;
		if (command == CMD_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end
		end else if (empty) begin
			status_d = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q   <= del_ok ? entries[0] : '0;
			status_q    <= status_d;
			res_count_q <= count_d;
		end
	end

	assign res_valid     = res_valid_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign entry_count   = ENTRY_COUNT_W'(res_count_q);

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count exceeds capacity");

	// The fill count moves only when an item is accepted.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("fill count changed without an accepted item");

	// A full status is only reported with the queue at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && status_q == ST_FULL) |-> (res_count_q == CNT_W'(CAPACITY)))
		else $error("full status with queue not at capacity");

	// An empty status comes with an empty queue and a zero value.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && status_q == ST_EMPTY) |-> (res_count_q == '0 && removed_q == '0))
		else $error("empty status with entries or a nonzero value");

endmodule

// ===== tb/smpq_result_monitor.sv =====
`timescale 1ns / 1ps

// Watches the command and result channels of the queue. It keeps its own
// sorted copy of the held values, predicts the result of every accepted
// item and compares each accepted result with the oldest prediction.
module smpq_result_monitor
	import smpq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	input  logic                     cmd_stall,
	input  logic                     command,
	input  logic signed [VAL_W-1:0]  value,
	input  logic                     res_valid,
	input  logic                     res_stall,
	input  logic signed [VAL_W-1:0]  removed_value,
	input  logic [1:0]               status,
	input  logic [ENTRY_COUNT_W-1:0] entry_count,
	output int                       mismatch_count,
	output int                       outstanding,
	output int                       results_seen,
	output int                       full_rejects,
	output int                       empty_deletes
);

	typedef struct packed {
		logic signed [VAL_W-1:0]  removed_value;
		status_t                  status;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} queue_result_t;

	// Held values in ascending order, and the results still owed.
	logic signed [VAL_W-1:0] held_values [$];
	queue_result_t           owed_results [$];

	// Applies one command to the held values and returns its result.
	// A new value goes after every equal value already held.
	function automatic queue_result_t apply_command(cmd_t op,
			logic signed [VAL_W-1:0] operand);
		queue_result_t res;
		int pos;
		res.removed_value = '0;
		res.status = ST_OK;
		if (op == CMD_INSERT) begin
			if (held_values.size() >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_values.size() && held_values[pos] <= operand)
					pos++;
				held_values.insert(pos, operand);
			end
		end else if (held_values.size() == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.removed_value = held_values.pop_front();
		end
		res.entry_count = ENTRY_COUNT_W'(held_values.size());
		return res;
	endfunction

	task automatic flag_mismatch(string field, logic signed [VAL_W-1:0] want,
			logic signed [VAL_W-1:0] got);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// Results are checked before the item of the same edge is predicted;
	// an item can never produce its result at the edge it is taken.
	always @(posedge clk or negedge arst_n) begin : watch
		queue_result_t want;
		if (!arst_n) begin
			held_values.delete();
			owed_results.delete();
		end else begin
			if (res_valid && !res_stall) begin
				results_seen++;
				if (owed_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with no item outstanding, value %0d status %0d",
						$time, removed_value, status);
				end else begin
					want = owed_results.pop_front();
					if (removed_value !== want.removed_value)
						flag_mismatch("removed_value", want.removed_value, removed_value);
					if (status !== want.status)
						flag_mismatch("status", want.status, status);
					if (entry_count !== want.entry_count)
						flag_mismatch("entry_count", want.entry_count, entry_count);
				end
			end
			if (cmd_valid && !cmd_stall) begin
				want = apply_command(cmd_t'(command), value);
				if (want.status == ST_FULL)
					full_rejects++;
				if (want.status == ST_EMPTY)
					empty_deletes++;
				owed_results.push_back(want);
			end
		end
		outstanding = owed_results.size();
	end

endmodule

// ===== tb/tb_sorted_min_priority_queue_unit.sv =====
`timescale 1ns / 1ps

module tb_sorted_min_priority_queue_unit;
	import smpq_pkg::*;

	localparam int RANDOM_ITEMS = 850;

	// Values at the ends of the signed range, duplicates and bit patterns.
	localparam logic signed [VAL_W-1:0] EDGE_VALUES [16] = '{
		32'sh7FFFFFFF, 32'sh80000000, -32'sd1, 32'sd0,
		32'sd1, 32'sd5, 32'sd5, -32'sd5,
		32'sh80000000, 32'sh7FFFFFFF, 32'sd2, 32'sd2,
		32'sd100, -32'sd100, 32'sh55555555, 32'shAAAAAAAA
	};

	logic                     clk;
	logic                     arst_n;
	logic                     cmd_valid;
	logic                     cmd_stall;
	logic                     command;
	logic signed [VAL_W-1:0]  value;
	logic                     res_valid;
	logic                     res_stall;
	logic signed [VAL_W-1:0]  removed_value;
	logic [1:0]               status;
	logic [ENTRY_COUNT_W-1:0] entry_count;

	int mismatch_count;
	int outstanding;
	int results_seen;
	int full_rejects;
	int empty_deletes;
	int items_sent;
	bit steady;

	sorted_min_priority_queue_unit uut (.*);

	smpq_result_monitor monitor (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the queue stops answering.
	initial begin
		#2_000_000;
		$display("%0t: run did not complete in time", $time);
		$display("TB_ERROR");
		$finish;
	end

	// Offers one item after a random gap, none when steady, and waits until it is taken.
	task automatic send_item(cmd_t op, logic signed [VAL_W-1:0] operand);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= op;
		value <= operand;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		items_sent++;
	endtask

	// Holds the sender off until every owed result has come back.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// Mostly full-range values, with small values that collide often and
	// values at or near the ends of the signed range.
	function automatic logic signed [VAL_W-1:0] pick_operand();
		case ($urandom_range(0, 5))
			3: return int'($urandom_range(0, 8)) - 4;
			4: begin
				case ($urandom_range(0, 3))
					0: return 32'sh80000000;
					1: return 32'sh7FFFFFFF;
					2: return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			5: return ($urandom_range(0, 1) == 0) ? 32'sh80000000 + $urandom_range(0, 3)
				: 32'sh7FFFFFFF - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// Receiver: a random stall before each result, none in steady stretches.
	initial begin
		int hold;
		hold = 0;
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall)
				hold = steady ? 0 : $urandom_range(0, 6);
			else if (res_valid && hold > 0)
				hold--;
			res_stall <= (hold > 0);
		end
	end

	initial begin
		cmd_t op;
		int insert_pct;
		int phase;
		int directed_count;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		command = 1'b0;
		value = '0;
		steady = 1'b0;
		items_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Delete from an empty queue, fill it past capacity, then take
		// the smallest values back out.
		send_item(CMD_DELETE, 32'sh7FFFFFFF);
		foreach (EDGE_VALUES[i])
			send_item(CMD_INSERT, EDGE_VALUES[i]);
		send_item(CMD_INSERT, 32'sd7);
		repeat (6) send_item(CMD_DELETE, $urandom);
		drain_results();
		directed_count = items_sent;

		// Random phases lean toward inserts or deletes so that the queue
		// swings between full and empty; some phases run without idling.
		phase = 0;
		while (items_sent < directed_count + RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: insert_pct = 80;
				1: insert_pct = 25;
				default: insert_pct = 55;
			endcase
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(8, 40)) begin
				op = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
				send_item(op, pick_operand());
			end
			phase++;
			if (phase % 6 == 0)
				drain_results();
		end
		steady = 1'b0;

		// Let the last results come back, then give the verdict.
		cmd_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		$display("Sent %0d items and checked %0d results.", items_sent, results_seen);
		$display("Inserts refused on a full queue: %0d, deletes on an empty queue: %0d.",
			full_rejects, empty_deletes);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/sorted_min_priority_queue_unit.sv
tb/smpq_result_monitor.sv
tb/tb_sorted_min_priority_queue_unit.sv
